/* rtl/kedfr_pkg.sv */
// shared types and constants of the key event deframer
package kedfr_pkg;

    // bytes in one key packet, the last one is padding
    localparam int unsigned PACKET_BYTES = 8;

    // packet type codes
    localparam logic [7:0] TYPE_DOWN = 8'd1;
    localparam logic [7:0] TYPE_UP   = 8'd2;

    // configuration register indexes
    localparam logic [1:0] REG_CTRL_MASK = 2'd0;
    localparam logic [1:0] REG_C_CODE    = 2'd1;
    localparam logic [1:0] REG_F12_CODE  = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]  CTRL_MASK_RST = 8'd1;
    localparam logic [15:0] C_CODE_RST    = 16'd6;
    localparam logic [15:0] F12_CODE_RST  = 16'd69;

    // operation carried by an input item
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_FLUSH = 2'd2
    } t_op;

    // result kind of an output item
    typedef enum logic [2:0] {
        KIND_ABSORBED = 3'd0,
        KIND_INJECTED = 3'd1,
        KIND_READ     = 3'd2,
        KIND_EMPTY    = 3'd3,
        KIND_FILTERED = 3'd4
    } t_kind;

    // one stored key event, 56 bits
    typedef struct packed {
        logic [7:0]  ev_type;
        logic [7:0]  mods;
        logic [15:0] code;
        logic [15:0] chr;
        logic [7:0]  rep;
    } t_event;

    localparam int unsigned EVENT_W = $bits(t_event);

    // control states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

/* rtl/kedfr_ram.sv */
// generic simple dual-port ram with registered read
module kedfr_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/key_event_deframe_filter_ring.sv */
// Key event deframer: gathers pushed bytes into 8-byte little-endian key packets, drops
// packets that fail the type, zero-code and stop-key filter, and queues the rest in a
// RING_DEPTH-entry ring held in a synchronous RAM that overwrites its oldest event when
// full. A push, flush or unused op loads its result at accept; a non-empty read issues the
// registered ring RAM read and passes through S_READ, where no new item is accepted. One item is in
// work at a time and a finished result waits in the output register, which may be taken
// in the same cycle the next item is accepted. No clearing pass is needed after reset.
module key_event_deframe_filter_ring #(
    parameter int RING_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_rx_byte,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_result_kind,
    output logic        o_key_released,
    output logic [7:0]  o_event_type,
    output logic [7:0]  o_modifiers,
    output logic [15:0] o_key_code,
    output logic [15:0] o_unicode_char,
    output logic [7:0]  o_repeat_value,
    output logic        o_dropped_oldest,
    output logic [6:0]  o_queued_count
);

    import kedfr_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    // configuration registers
    logic [7:0]  r_ctrl_mask;
    logic [15:0] r_c_code;
    logic [15:0] r_f12_code;

    // deframer and ring state
    logic [7:0]       r_pkt [PACKET_BYTES-1];
    logic [2:0]       r_byte_cnt, n_byte_cnt;
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_state           r_state, n_state;

    // output register
    logic        r_out_valid, n_out_valid;
    t_kind       r_out_kind;
    t_event      r_out_ev;
    logic        r_out_dropped;
    logic [CNT_W-1:0] r_out_count;

    logic             w_accept;
    logic             w_cfg_wr;
    logic             w_last_byte;
    logic             w_blocked;
    logic             w_full;
    logic             w_empty;
    logic             w_inject;
    logic             w_rd_issue;
    logic             w_load;
    t_event           w_pkt_ev;
    t_event           w_ram_rd;
    t_kind            w_kind;
    t_event           w_ev;
    logic             w_dropped;
    logic [PTR_W-1:0] w_wptr_inc;
    logic [PTR_W-1:0] w_rptr_inc;
    logic [CNT_W+6:0] w_count_wide;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_mask <= CTRL_MASK_RST;
            r_c_code    <= C_CODE_RST;
            r_f12_code  <= F12_CODE_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_CTRL_MASK: r_ctrl_mask <= pwdata[7:0];
                REG_C_CODE:    r_c_code    <= pwdata[15:0];
                REG_F12_CODE:  r_f12_code  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // configuration read back
    always_comb begin
        case (paddr[3:2])
            REG_CTRL_MASK: prdata = {24'd0, r_ctrl_mask};
            REG_C_CODE:    prdata = {16'd0, r_c_code};
            REG_F12_CODE:  prdata = {16'd0, r_f12_code};
            default:       prdata = 32'd0;
        endcase
    end

    // assemble the completed packet, padding byte discarded
    always_comb begin
        w_pkt_ev.ev_type = r_pkt[0];
        w_pkt_ev.mods    = r_pkt[1];
        w_pkt_ev.code    = {r_pkt[3], r_pkt[2]};
        w_pkt_ev.chr     = {r_pkt[5], r_pkt[4]};
        w_pkt_ev.rep     = r_pkt[6];
    end

    // stop-key and sanity filter
    assign w_blocked = !(w_pkt_ev.ev_type inside {TYPE_DOWN, TYPE_UP})
                    || (w_pkt_ev.code == 16'd0)
                    || (((w_pkt_ev.mods & r_ctrl_mask) != 8'd0) && (w_pkt_ev.code == r_c_code))
                    || (w_pkt_ev.code == r_f12_code);

    assign w_last_byte = (r_byte_cnt == 3'(PACKET_BYTES - 1));
    assign w_full      = (r_count == CNT_W'(RING_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_wptr_inc  = (r_wptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign w_rptr_inc  = (r_rptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    // item decode: ring updates and, but for a non-empty read, the result loaded at accept
    always_comb begin
        n_byte_cnt = r_byte_cnt;
        n_wptr     = r_wptr;
        n_rptr     = r_rptr;
        n_count    = r_count;
        w_inject   = 1'b0;
        w_rd_issue = 1'b0;
        w_load     = 1'b0;
        w_kind     = KIND_ABSORBED;
        w_ev       = '0;
        w_dropped  = 1'b0;
        if (w_accept) begin
            w_load = 1'b1;
            case (i_op)
                OP_PUSH: begin
                    if (!w_last_byte) begin
                        n_byte_cnt = r_byte_cnt + 1'b1;
                    end else begin
                        n_byte_cnt = '0;
                        w_ev       = w_pkt_ev;
                        if (w_blocked) begin
                            w_kind = KIND_FILTERED;
                        end else begin
                            w_kind    = KIND_INJECTED;
                            w_inject  = 1'b1;
                            w_dropped = w_full;
                            n_wptr    = w_wptr_inc;
                            if (w_full) begin
                                n_rptr = w_rptr_inc;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                end
                OP_READ: begin
                    if (w_empty) begin
                        w_kind = KIND_EMPTY;
                    end else begin
                        w_load     = 1'b0;
                        w_rd_issue = 1'b1;
                        n_rptr     = w_rptr_inc;
                        n_count    = r_count - 1'b1;
                    end
                end
                OP_FLUSH: begin
                    n_byte_cnt = '0;
                    n_wptr     = '0;
                    n_rptr     = '0;
                    n_count    = '0;
                end
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_rd_issue) n_state = S_READ;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            S_IDLE:  o_in_ready = !r_out_valid || i_out_ready;
            S_READ:  o_in_ready = 1'b0;
            default: o_in_ready = 1'b0;
        endcase
    end

    // output valid: set when a result is loaded, cleared when taken
    always_comb begin
        if (w_load || (r_state == S_READ)) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_byte_cnt  <= '0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_byte_cnt  <= n_byte_cnt;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // partial packet bytes
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_op == OP_PUSH) && !w_last_byte) begin
            r_pkt[r_byte_cnt] <= i_rx_byte;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_out_kind    <= KIND_READ;
            r_out_ev      <= w_ram_rd;
            r_out_dropped <= 1'b0;
            r_out_count   <= r_count;
        end else if (w_load) begin
            r_out_kind    <= w_kind;
            r_out_ev      <= w_ev;
            r_out_dropped <= w_dropped;
            r_out_count   <= n_count;
        end
    end

    // event ring storage
    kedfr_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_inject),
        .i_wr_addr (r_wptr),
        .i_wr_data (w_pkt_ev),
        .i_rd_en   (w_rd_issue),
        .i_rd_addr (r_rptr),
        .o_rd_data (w_ram_rd)
    );

    // output ports
    assign w_count_wide     = (CNT_W + 7)'(r_out_count);
    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out_kind;
    assign o_key_released   = (r_out_ev.ev_type == TYPE_UP);
    assign o_event_type     = r_out_ev.ev_type;
    assign o_modifiers      = r_out_ev.mods;
    assign o_key_code       = r_out_ev.code;
    assign o_unicode_char   = r_out_ev.chr;
    assign o_repeat_value   = r_out_ev.rep;
    assign o_dropped_oldest = r_out_dropped;
    assign o_queued_count   = w_count_wide[6:0];

endmodule

/* tb/testbench.sv */
// self-checking bench for the key event deframer: directed table, random phases, item scoreboard
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kedfr_pkg::*;

    localparam int         RING_SLOTS     = 64;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         LONG_HOLD      = 300;
    localparam int         DRAIN_CYCLES   = 4;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [1:0] REG_UNUSED     = 2'd3;

    // one expected result item
    typedef struct packed {
        t_kind      kind;
        logic       released;
        t_event     ev;
        logic       dropped;
        logic [6:0] count;
    } t_key_result;

    // one row of the directed table
    typedef struct {
        logic [1:0]  op;
        logic [7:0]  data;
        bit          typed;
        t_key_result want;
    } t_directed_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_result_kind;
    logic        o_key_released;
    logic [7:0]  o_event_type;
    logic [7:0]  o_modifiers;
    logic [15:0] o_key_code;
    logic [15:0] o_unicode_char;
    logic [7:0]  o_repeat_value;
    logic        o_dropped_oldest;
    logic [6:0]  o_queued_count;

    // filter settings and deframer state as the bench sees them
    logic [7:0]  cfg_ctrl_mask;
    logic [15:0] cfg_c_code;
    logic [15:0] cfg_f12_code;
    logic [7:0]  pkt_bytes [7];
    int          pkt_len;
    t_event      key_ring [RING_SLOTS];
    int          ring_wr;
    int          ring_rd;
    int          ring_fill;

    t_key_result   pending_results [$];
    t_directed_row directed_rows [$];
    t_key_result   front_result;

    int mismatches  = 0;
    int items_sent  = 0;
    int tx_gap_pct  = 10;
    int rx_gap_pct  = 10;
    int rx_gap      = 0;
    int rx_cycles   = 0;
    int long_hold   = 0;
    int quiet_count = 0;
    bit idling_on   = 1'b1;
    bit traffic_on  = 1'b0;

    // random traffic phases: length, share of reads, flushes and filter traps
    int phase_items     [6] = '{300, 700, 250, 250, 200, 200};
    int phase_read_pct  [6] = '{20, 0, 45, 25, 25, 25};
    int phase_flush_pct [6] = '{3, 0, 2, 3, 3, 3};
    int phase_trap_pct  [6] = '{30, 5, 30, 35, 35, 35};

    logic [7:0] pkt_full_scale [8] = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    logic [7:0] pkt_ctrl_c     [8] = '{8'h02, 8'h01, 8'h06, 8'h00, 8'h41, 8'h00, 8'h00, 8'hAA};

    key_event_deframe_filter_ring #(
        .RING_DEPTH(RING_SLOTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_key_released   (o_key_released),
        .o_event_type     (o_event_type),
        .o_modifiers      (o_modifiers),
        .o_key_code       (o_key_code),
        .o_unicode_char   (o_unicode_char),
        .o_repeat_value   (o_repeat_value),
        .o_dropped_oldest (o_dropped_oldest),
        .o_queued_count   (o_queued_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result with every packet field cleared
    function automatic t_key_result plain_result(input t_kind kind, input logic [6:0] count);
        t_key_result r;
        r       = '0;
        r.kind  = kind;
        r.count = count;
        return r;
    endfunction

    // expected result of one item, advancing the deframer and ring state
    function automatic t_key_result predict_key_result(input logic [1:0] op,
                                                       input logic [7:0] data);
        t_key_result r;
        t_event      ev;
        r      = '0;
        r.kind = KIND_ABSORBED;
        ev     = '0;
        case (op)
            OP_PUSH: begin
                if (pkt_len < PACKET_BYTES - 1) begin
                    pkt_bytes[pkt_len] = data;
                    pkt_len++;
                end else begin
                    // pad byte closes the packet and is thrown away
                    ev.ev_type = pkt_bytes[0];
                    ev.mods    = pkt_bytes[1];
                    ev.code    = {pkt_bytes[3], pkt_bytes[2]};
                    ev.chr     = {pkt_bytes[5], pkt_bytes[4]};
                    ev.rep     = pkt_bytes[6];
                    pkt_len    = 0;
                    r.ev       = ev;
                    r.released = (ev.ev_type == TYPE_UP);
                    if ((ev.ev_type != TYPE_DOWN && ev.ev_type != TYPE_UP) || ev.code == 16'h0000
                        || ((ev.mods & cfg_ctrl_mask) != 8'h00 && ev.code == cfg_c_code)
                        || ev.code == cfg_f12_code) begin
                        r.kind = KIND_FILTERED;
                    end else begin
                        // full ring gives up its oldest event
                        if (ring_fill >= RING_SLOTS) begin
                            ring_rd   = (ring_rd + 1) % RING_SLOTS;
                            ring_fill--;
                            r.dropped = 1'b1;
                        end
                        key_ring[ring_wr] = ev;
                        ring_wr           = (ring_wr + 1) % RING_SLOTS;
                        ring_fill++;
                        r.kind = KIND_INJECTED;
                    end
                end
            end
            OP_READ: begin
                if (ring_fill == 0) begin
                    r.kind = KIND_EMPTY;
                end else begin
                    ev         = key_ring[ring_rd];
                    ring_rd    = (ring_rd + 1) % RING_SLOTS;
                    ring_fill--;
                    r.kind     = KIND_READ;
                    r.ev       = ev;
                    r.released = (ev.ev_type == TYPE_UP);
                end
            end
            OP_FLUSH: begin
                ring_wr   = 0;
                ring_rd   = 0;
                ring_fill = 0;
                pkt_len   = 0;
            end
            default: ;
        endcase
        r.count = 7'(ring_fill);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    function automatic void add_row(input logic [1:0] op, input logic [7:0] data,
                                    input bit typed, input t_key_result want);
        t_directed_row row;
        row.op    = op;
        row.data  = data;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // offer one item, with an occasional gap first, and record its expected result
    task automatic send_item(input logic [1:0] op, input logic [7:0] data);
        t_key_result r;
        if (items_sent % 48 == 0)
            tx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(5, 35));
        if (idling_on && $urandom_range(0, 99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_rx_byte  <= data;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        r = predict_key_result(op, data);
        pending_results.push_back(r);
        items_sent++;
    endtask

    // well-formed packet, sometimes baited to hit one of the filter rules
    task automatic send_key_packet(input int trap_pct);
        t_event     ev;
        logic [7:0] frame [8];
        ev.ev_type = ($urandom_range(0, 1) == 1) ? TYPE_UP : TYPE_DOWN;
        ev.mods    = 8'($urandom);
        ev.code    = 16'($urandom);
        ev.chr     = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        ev.rep     = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
        if ($urandom_range(0, 99) < trap_pct) begin
            case ($urandom_range(0, 3))
                0: ev.ev_type = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(3, 255));
                1: ev.code = 16'h0000;
                2: begin
                    ev.code = cfg_c_code;
                    if ($urandom_range(0, 1) == 1)
                        ev.mods = ev.mods | cfg_ctrl_mask;
                end
                default: ev.code = cfg_f12_code;
            endcase
        end
        frame = '{ev.ev_type, ev.mods, ev.code[7:0], ev.code[15:8],
                  ev.chr[7:0], ev.chr[15:8], ev.rep, 8'($urandom)};
        foreach (frame[k])
            send_item(OP_PUSH, frame[k]);
    endtask

    // apb write: setup cycle, access cycle, then the bus returns to idle
    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [3:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_registers();
        logic [31:0] rd;
        apb_read({REG_CTRL_MASK, 2'b00}, rd);
        compare_field("ctrl_modifier_mask", {24'd0, cfg_ctrl_mask}, {24'd0, rd[7:0]});
        apb_read({REG_C_CODE, 2'b00}, rd);
        compare_field("stop_key_c_code", {16'd0, cfg_c_code}, {16'd0, rd[15:0]});
        apb_read({REG_F12_CODE, 2'b00}, rd);
        compare_field("stop_key_f12_code", {16'd0, cfg_f12_code}, {16'd0, rd[15:0]});
    endtask

    // upper data bits are ignored by the block, so they carry whatever the caller passes
    task automatic apply_filter_config(input logic [31:0] mask_word, input logic [31:0] c_word,
                                       input logic [31:0] f12_word);
        apb_write({REG_CTRL_MASK, 2'b00}, mask_word);
        cfg_ctrl_mask = mask_word[7:0];
        apb_write({REG_C_CODE, 2'b00}, c_word);
        cfg_c_code = c_word[15:0];
        apb_write({REG_F12_CODE, 2'b00}, f12_word);
        cfg_f12_code = f12_word[15:0];
    endtask

    // let every outstanding result drain, with the input channel held idle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result checking and receiver back-pressure
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result item with none expected, kind %0h", $time,
                         o_result_kind);
                mismatches++;
            end else begin
                front_result = pending_results.pop_front();
                compare_field("result_kind", 32'(front_result.kind), 32'(o_result_kind));
                compare_field("key_released", 32'(front_result.released), 32'(o_key_released));
                compare_field("event_type", 32'(front_result.ev.ev_type), 32'(o_event_type));
                compare_field("modifiers", 32'(front_result.ev.mods), 32'(o_modifiers));
                compare_field("key_code", 32'(front_result.ev.code), 32'(o_key_code));
                compare_field("unicode_char", 32'(front_result.ev.chr), 32'(o_unicode_char));
                compare_field("repeat_value", 32'(front_result.ev.rep), 32'(o_repeat_value));
                compare_field("dropped_oldest", 32'(front_result.dropped),
                              32'(o_dropped_oldest));
                compare_field("queued_count", 32'(front_result.count), 32'(o_queued_count));
            end
        end
        rx_cycles++;
        if (rx_cycles % 64 == 0)
            rx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(5, 35));
        if (!traffic_on) begin
            i_out_ready <= 1'b0;
        end else if (long_hold > 0) begin
            i_out_ready <= 1'b0;
            long_hold--;
        end else if (rx_gap > 0) begin
            i_out_ready <= 1'b0;
            rx_gap--;
        end else if (idling_on && $urandom_range(0, 99) < rx_gap_pct) begin
            rx_gap = $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted input item or taken result item
    always @(posedge i_clk) begin
        if (!traffic_on || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_count = 0;
        end else begin
            quiet_count++;
            if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no item moved for %0d cycles", $time, quiet_count);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        int p;
        int roll;
        int phase_end;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_PUSH;
        i_rx_byte   = 8'h00;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 4'h0;
        pwdata      = 32'h0;
        cfg_ctrl_mask = CTRL_MASK_RST;
        cfg_c_code    = C_CODE_RST;
        cfg_f12_code  = F12_CODE_RST;
        pkt_len   = 0;
        ring_wr   = 0;
        ring_rd   = 0;
        ring_fill = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        traffic_on = 1'b1;
        check_registers();

        // directed table: empty read, unused op, full-scale packet and its read back, flush of a
        // partial packet, and a ctrl+c packet that the default filter drops
        add_row(OP_READ, 8'h00, 1'b1, plain_result(KIND_EMPTY, 7'd0));
        add_row(OP_UNUSED, 8'hFF, 1'b1, plain_result(KIND_ABSORBED, 7'd0));
        foreach (pkt_full_scale[k])
            add_row(OP_PUSH, pkt_full_scale[k], k < 7, plain_result(KIND_ABSORBED, 7'd0));
        add_row(OP_READ, 8'hFF, 1'b0, plain_result(KIND_READ, 7'd0));
        add_row(OP_READ, 8'h00, 1'b1, plain_result(KIND_EMPTY, 7'd0));
        add_row(OP_PUSH, 8'h02, 1'b1, plain_result(KIND_ABSORBED, 7'd0));
        add_row(OP_PUSH, 8'h00, 1'b1, plain_result(KIND_ABSORBED, 7'd0));
        add_row(OP_PUSH, 8'h00, 1'b1, plain_result(KIND_ABSORBED, 7'd0));
        add_row(OP_FLUSH, 8'h00, 1'b1, plain_result(KIND_ABSORBED, 7'd0));
        foreach (pkt_ctrl_c[k])
            add_row(OP_PUSH, pkt_ctrl_c[k], k < 7, plain_result(KIND_ABSORBED, 7'd0));
        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].op, directed_rows[k].data);
            if (directed_rows[k].typed)
                pending_results[pending_results.size() - 1] = directed_rows[k].want;
        end

        // random phases, each under its own filter settings
        phase_end = items_sent;
        for (p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: apply_filter_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                    2: begin
                        apply_filter_config({24'($urandom), 8'h00}, {16'($urandom), 16'h0000},
                                            {16'($urandom), 16'h0000});
                        // write to an address past the last register must change nothing
                        apb_write({REG_UNUSED, 2'b00}, $urandom);
                    end
                    default: apply_filter_config($urandom, $urandom, $urandom);
                endcase
                check_registers();
            end
            // ring-filling phase starts with the receiver held off for a long while
            if (p == 1)
                long_hold = LONG_HOLD;
            // last phase runs with no idling on either side
            if (p == 5)
                idling_on = 1'b0;
            phase_end += phase_items[p];
            while (items_sent < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < phase_read_pct[p]) begin
                    repeat ($urandom_range(1, 4)) send_item(OP_READ, 8'($urandom));
                end else if (roll < phase_read_pct[p] + phase_flush_pct[p]) begin
                    send_item(OP_FLUSH, 8'($urandom));
                end else if (roll < phase_read_pct[p] + phase_flush_pct[p] + 6) begin
                    // noise: any op, breaks packet alignment
                    repeat ($urandom_range(1, 7))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom));
                end else begin
                    send_key_packet(phase_trap_pct[p]);
                end
            end
        end

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
